// ===== rtl/hpt_pkg.sv =====
// Shared types and constants for the homogeneous point transform core.
package hpt_pkg;

  localparam int unsigned CoordW = 32;  // Q16.16 coordinate
  localparam int unsigned FracW  = 16;
  localparam int unsigned HW     = 49;  // signed homogeneous sum, |h| < 2^48
  localparam int unsigned MagW   = 48;  // magnitude of h
  localparam int unsigned QuoW   = 32;  // quotient bits produced by the divider
  localparam int unsigned NumLanes = 3;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned NumCfg = 8;

  // One coordinate lane inside the divider pipeline
  typedef struct packed {
    logic [MagW-1:0]   rem;  // partial remainder, below the divisor unless ovf is set
    logic [QuoW-1:0]   low;  // dividend bits still to shift in
    logic [QuoW-1:0]   quo;  // quotient bits developed so far
    logic              neg;  // result sign
    logic              ovf;  // quotient is 2^32 or more
  } hpt_lane_t;

  // Everything that travels through one divider step
  typedef struct packed {
    hpt_lane_t [NumLanes-1:0] lane;
    logic [MagW-1:0]          den;
    logic                     wz;
  } hpt_div_t;

endpackage

// ===== rtl/hpt_matmul.sv =====
// Matrix multiply, row sums and divider setup: three register stages.
module hpt_matmul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [hpt_pkg::CoordW-1:0]  x_i,
  input  logic signed [hpt_pkg::CoordW-1:0]  y_i,
  input  logic signed [hpt_pkg::CoordW-1:0]  z_i,
  input  logic signed [hpt_pkg::CoordW-1:0]  mat_i [16],
  output logic                               valid_o,
  output hpt_pkg::hpt_div_t                  div_o
);

  logic signed [2*hpt_pkg::CoordW-1:0] prod_q [4][3];
  logic signed [hpt_pkg::CoordW-1:0]   off_q [4];
  logic signed [hpt_pkg::HW-1:0]       h_d [4];
  logic signed [hpt_pkg::HW-1:0]       h_q [4];
  logic signed [hpt_pkg::CoordW-1:0]   pt [3];
  logic [hpt_pkg::MagW-1:0]            mag [4];
  hpt_pkg::hpt_div_t                   div_d, div_q;
  logic [2:0]                          vld_q;

  assign pt[0] = x_i;
  assign pt[1] = y_i;
  assign pt[2] = z_i;

  // Stage 1: twelve products, exact Q32.32
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= mat_i[4*r+c] * pt[c];
        end
        off_q[r] <= mat_i[4*r+3];
      end
    end
  end

  // Stage 2: floor each product to Q16.16 and sum a row
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      h_d[r] = hpt_pkg::HW'(prod_q[r][0] >>> hpt_pkg::FracW)
             + hpt_pkg::HW'(prod_q[r][1] >>> hpt_pkg::FracW)
             + hpt_pkg::HW'(prod_q[r][2] >>> hpt_pkg::FracW)
             + hpt_pkg::HW'(off_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q <= h_d;
    end
  end

  // Stage 3: magnitudes, signs, overflow check and divider seed
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mag[r] = h_q[r][hpt_pkg::HW-1] ? hpt_pkg::MagW'(-h_q[r]) : hpt_pkg::MagW'(h_q[r]);
    end
    div_d.den = mag[3];
    div_d.wz  = (h_q[3] == '0);
    for (int l = 0; l < hpt_pkg::NumLanes; l++) begin
      div_d.lane[l].rem = {16'b0, mag[l][hpt_pkg::MagW-1:hpt_pkg::FracW]};
      div_d.lane[l].low = {mag[l][hpt_pkg::FracW-1:0], 16'b0};
      div_d.lane[l].quo = '0;
      div_d.lane[l].neg = h_q[l][hpt_pkg::HW-1] ^ h_q[3][hpt_pkg::HW-1];
      div_d.lane[l].ovf = ({16'b0, mag[l]} >= {mag[3], 16'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  // Valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign div_o   = div_q;

endmodule

// ===== rtl/hpt_div_step.sv =====
// One restoring-division step: one quotient bit for each of three lanes.
module hpt_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  hpt_pkg::hpt_div_t div_i,
  output logic              valid_o,
  output hpt_pkg::hpt_div_t div_o
);

  hpt_pkg::hpt_div_t      div_d, div_q;
  logic                   vld_q;
  logic [hpt_pkg::MagW:0] trial [hpt_pkg::NumLanes];
  logic                   ge [hpt_pkg::NumLanes];

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    div_d = div_i;
    for (int l = 0; l < hpt_pkg::NumLanes; l++) begin
      trial[l] = {div_i.lane[l].rem, div_i.lane[l].low[hpt_pkg::QuoW-1]};
      ge[l]    = (trial[l] >= {1'b0, div_i.den});
      div_d.lane[l].rem = ge[l] ? hpt_pkg::MagW'(trial[l] - {1'b0, div_i.den})
                                : hpt_pkg::MagW'(trial[l]);
      div_d.lane[l].low = {div_i.lane[l].low[hpt_pkg::QuoW-2:0], 1'b0};
      div_d.lane[l].quo = {div_i.lane[l].quo[hpt_pkg::QuoW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  assign valid_o = vld_q;
  assign div_o   = div_q;

endmodule

// ===== rtl/homogeneous_point_transform_core.sv =====
// Top level: matrix registers, transform pipeline, divider chain, output stage.
//
// The core takes one point per cycle unless stalled and returns one result
// per point, in order. There are three register stages for the matrix
// multiply, row sums and divider setup, then 32 divider stages (one quotient
// bit per stage, three lanes sharing the w divisor), then the output register,
// which also takes the sign fixup and clamp. The whole pipeline advances
// together; it stalls only while a result waits at the output. Matrix writes
// take effect on the next accepted point.
module homogeneous_point_transform_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hpt_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [hpt_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [hpt_pkg::CoordW-1:0]   x_in_i,
  input  logic signed [hpt_pkg::CoordW-1:0]   y_in_i,
  input  logic signed [hpt_pkg::CoordW-1:0]   z_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [hpt_pkg::CoordW-1:0]   x_out_o,
  output logic signed [hpt_pkg::CoordW-1:0]   y_out_o,
  output logic signed [hpt_pkg::CoordW-1:0]   z_out_o,
  output logic                                w_zero_o,
  output logic                                saturated_o
);

  localparam int unsigned NumSteps = hpt_pkg::QuoW;

  logic signed [hpt_pkg::CoordW-1:0] mat_q [16];
  logic                              en;
  logic                              vld [NumSteps+1];
  hpt_pkg::hpt_div_t                 div [NumSteps+1];
  logic [hpt_pkg::CoordW-1:0]        coord_d [hpt_pkg::NumLanes];
  logic [hpt_pkg::CoordW-1:0]        coord_q [hpt_pkg::NumLanes];
  logic                              sat_d, sat_q, wz_q, out_vld_q;
  logic                              lane_sat [hpt_pkg::NumLanes];

  // Matrix registers, two entries per write, high word is the lower column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < hpt_pkg::CfgIdxW'(hpt_pkg::NumCfg))) begin
      mat_q[{cfg_idx_i[2:0], 1'b0}] <= cfg_data_i[63:32];
      mat_q[{cfg_idx_i[2:0], 1'b1}] <= cfg_data_i[31:0];
    end
  end

  // Global advance: hold everything while a result waits
  assign en         = !(out_vld_q && !out_ready_i);
  assign in_ready_o = en;

  hpt_matmul u_matmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .x_i     (x_in_i),
    .y_i     (y_in_i),
    .z_i     (z_in_i),
    .mat_i   (mat_q),
    .valid_o (vld[0]),
    .div_o   (div[0])
  );

  // Divider chain, one quotient bit per stage
  for (genvar s = 0; s < NumSteps; s++) begin : g_div
    hpt_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[s]),
      .div_i   (div[s]),
      .valid_o (vld[s+1]),
      .div_o   (div[s+1])
    );
  end

  // Sign, clamp and zero-divisor handling
  always_comb begin
    sat_d = 1'b0;
    for (int l = 0; l < hpt_pkg::NumLanes; l++) begin
      lane_sat[l] = 1'b0;
      coord_d[l]  = '0;
      if (!div[NumSteps].wz) begin
        if (div[NumSteps].lane[l].neg) begin
          if (div[NumSteps].lane[l].ovf || (div[NumSteps].lane[l].quo > 32'h8000_0000)) begin
            lane_sat[l] = 1'b1;
            coord_d[l]  = 32'h8000_0000;
          end else begin
            coord_d[l] = -div[NumSteps].lane[l].quo;
          end
        end else begin
          if (div[NumSteps].lane[l].ovf || div[NumSteps].lane[l].quo[hpt_pkg::QuoW-1]) begin
            lane_sat[l] = 1'b1;
            coord_d[l]  = 32'h7FFF_FFFF;
          end else begin
            coord_d[l] = div[NumSteps].lane[l].quo;
          end
        end
      end
      sat_d = sat_d | lane_sat[l];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      coord_q <= coord_d;
      sat_q   <= sat_d;
      wz_q    <= div[NumSteps].wz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[NumSteps];
    end
  end

  assign out_valid_o = out_vld_q;
  assign x_out_o     = coord_q[0];
  assign y_out_o     = coord_q[1];
  assign z_out_o     = coord_q[2];
  assign w_zero_o    = wz_q;
  assign saturated_o = sat_q;

  // A zero divisor gives zero coordinates and no saturation
  a_wz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && w_zero_o) |-> (x_out_o == '0 && y_out_o == '0 && z_out_o == '0
                                   && !saturated_o))
    else $error("w_zero result carries nonzero payload");

  // Input side stalls exactly when a result is held
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == !(out_valid_o && !out_ready_i))
    else $error("in_ready out of step with output stall");

  // A held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(x_out_o) && $stable(w_zero_o)))
    else $error("stalled result changed");

  // The pipeline freezes while stalled
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld[NumSteps]))
    else $error("divider chain moved during stall");

endmodule

// ===== dv/tb_homogeneous_point_transform_core.sv =====
// Self-checking testbench for the homogeneous point transform core.
module tb_homogeneous_point_transform_core;

  typedef struct packed {
    logic signed [hpt_pkg::CoordW-1:0] x;
    logic signed [hpt_pkg::CoordW-1:0] y;
    logic signed [hpt_pkg::CoordW-1:0] z;
    logic                              wz;
    logic                              sat;
  } xform_t;

  localparam logic [hpt_pkg::CfgW-1:0] OneEntry = 64'h0000_0000_0001_0000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [hpt_pkg::CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [hpt_pkg::CfgW-1:0]          cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic signed [hpt_pkg::CoordW-1:0] x_in_i = '0;
  logic signed [hpt_pkg::CoordW-1:0] y_in_i = '0;
  logic signed [hpt_pkg::CoordW-1:0] z_in_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic signed [hpt_pkg::CoordW-1:0] x_out_o, y_out_o, z_out_o;
  logic                              w_zero_o, saturated_o;

  // Predictor state: matrix copy and pending results
  logic signed [hpt_pkg::CoordW-1:0] mtx [4][4];
  xform_t                   pending_q [$];
  int unsigned              err_count = 0;
  int unsigned              pts_sent = 0;
  int unsigned              res_seen = 0;
  int unsigned              wz_seen = 0;
  int unsigned              sat_seen = 0;
  bit                       idle_en = 1'b1;
  bit                       hold_req = 1'b0;

  homogeneous_point_transform_core dut (.*);

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #(20 * 400000);
    $display("Some tests failed");
    $finish;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Signed quotient with clamp to the Q16.16 range
  function automatic logic [hpt_pkg::CoordW-1:0] div_clamp(longint num, longint den,
                                                           inout bit sat);
    logic [63:0] mn, md, q;
    bit          neg;
    neg = (num < 0) != (den < 0);
    mn  = (num < 0) ? -num : num;
    md  = (den < 0) ? -den : den;
    q   = (mn << 16) / md;
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        q   = 64'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 64'h8000_0000) begin
      sat = 1'b1;
      q   = 64'h8000_0000;
    end
    q = 64'd0 - q;
    return q[31:0];
  endfunction

  // Expected result for one point under the current matrix
  function automatic xform_t transform_point(logic signed [hpt_pkg::CoordW-1:0] x,
                                             logic signed [hpt_pkg::CoordW-1:0] y,
                                             logic signed [hpt_pkg::CoordW-1:0] z);
    longint h [4];
    xform_t res;
    bit     sat;
    sat = 1'b0;
    for (int r = 0; r < 4; r++) begin
      h[r] = ((longint'(mtx[r][0]) * longint'(x)) >>> 16) +
             ((longint'(mtx[r][1]) * longint'(y)) >>> 16) +
             ((longint'(mtx[r][2]) * longint'(z)) >>> 16) + longint'(mtx[r][3]);
    end
    res = '0;
    if (h[3] == 0) begin
      res.wz = 1'b1;
      return res;
    end
    res.x   = div_clamp(h[0], h[3], sat);
    res.y   = div_clamp(h[1], h[3], sat);
    res.z   = div_clamp(h[2], h[3], sat);
    res.sat = sat;
    return res;
  endfunction

  // Register write; only while the core is idle
  task automatic write_reg(int unsigned idx, logic [hpt_pkg::CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx[hpt_pkg::CfgIdxW-1:0];
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < hpt_pkg::NumCfg) begin
      mtx[idx/2][(idx%2)*2]     = data[63:32];
      mtx[idx/2][(idx%2)*2 + 1] = data[31:0];
    end
    @(posedge clk_i);
  endtask

  task automatic load_matrix(logic [hpt_pkg::CfgW-1:0] regs [hpt_pkg::NumCfg]);
    for (int i = 0; i < hpt_pkg::NumCfg; i++) write_reg(i, regs[i]);
  endtask

  // Send one point; waits for its transfer, then for a random gap if one is picked
  task automatic send_point(logic signed [hpt_pkg::CoordW-1:0] x,
                            logic signed [hpt_pkg::CoordW-1:0] y,
                            logic signed [hpt_pkg::CoordW-1:0] z);
    int unsigned gap;
    in_valid_i <= 1'b1;
    x_in_i     <= x;
    y_in_i     <= y;
    z_in_i     <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q = {pending_q, transform_point(x, y, z)};
    pts_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until every result is in, then let the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  function automatic logic [hpt_pkg::CoordW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
      2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [hpt_pkg::CoordW-1:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h0;
      default: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
  endfunction

  // Receiver: random stretches of ready and stall, plus a long hold on request
  initial begin
    int unsigned left;
    int unsigned hold;
    bit          lvl;
    left = 0;
    hold = 0;
    lvl  = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) hold = 300;
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
        if (hold == 0) hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          lvl  = !idle_en || ($urandom_range(0, 2) != 0);
          left = lvl ? $urandom_range(1, 20) : pick_gap();
          if (left == 0) begin
            lvl  = 1'b1;
            left = 1;
          end
        end
        left--;
        out_ready_i <= lvl;
      end
    end
  end

  // Result checker
  initial begin
    xform_t exp_r;
    xform_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = '{x_out_o, y_out_o, z_out_o, w_zero_o, saturated_o};
        res_seen++;
        if (got.wz) wz_seen++;
        if (got.sat) sat_seen++;
        if (pending_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("ERROR: unexpected result transfer %p", got);
        end else begin
          exp_r = pending_q.pop_front();
          if (got !== exp_r) begin
            err_count++;
            if (err_count <= 10)
              $display("ERROR: x %h/%h y %h/%h z %h/%h wz %b/%b sat %b/%b (exp/got)",
                       exp_r.x, got.x, exp_r.y, got.y, exp_r.z, got.z,
                       exp_r.wz, got.wz, exp_r.sat, got.sat);
          end
        end
      end
    end
  end

  // Matrix at reset is zero, so w is zero for every point
  task automatic test_reset_matrix();
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_point(32'h0, 32'hFFFF_FFFF, 32'h1234_5678);
    drain();
  endtask

  // Identity and simple scalings, field extremes
  task automatic test_directed();
    logic [hpt_pkg::CfgW-1:0] regs [hpt_pkg::NumCfg];
    regs = '{{32'h0001_0000, 32'h0}, 64'h0, {32'h0, 32'h0001_0000}, 64'h0,
             64'h0, {32'h0001_0000, 32'h0}, 64'h0, OneEntry};
    load_matrix(regs);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
    send_point(32'h0001_8000, 32'hFFFE_8000, 32'h0000_4000);
    drain();
    // Doubling overflows the range in both directions
    write_reg(0, {32'h0002_0000, 32'h0});
    write_reg(7, {32'h0, 32'hFFFF_0000});
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000);
    send_point(32'h8000_0000, 32'h1000_0000, 32'hC000_0000);
    drain();
    // Tiny divisor: huge quotients
    write_reg(7, {32'h0, 32'h0000_0001});
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
    // w from the point: zero divisor when z is zero
    write_reg(6, 64'h0);
    write_reg(7, {32'h0001_0000, 32'h0});
    send_point(32'h0005_0000, 32'h0003_0000, 32'h0);
    send_point(32'h0005_0000, 32'h0003_0000, 32'hFFFE_0000);
    drain();
    // Indexes past the matrix are ignored
    for (int i = hpt_pkg::NumCfg; i < 16; i++) write_reg(i, $urandom());
    send_point(32'h0002_0000, 32'hFFFF_0000, 32'h0003_0000);
    drain();
  endtask

  // Register extremes
  task automatic test_reg_extremes();
    logic [hpt_pkg::CfgW-1:0] vals [4];
    vals = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_8000_0000,
             64'h7FFF_FFFF_7FFF_FFFF, 64'h0};
    foreach (vals[v]) begin
      for (int i = 0; i < hpt_pkg::NumCfg; i++) write_reg(i, vals[v]);
      for (int n = 0; n < 6; n++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  // Random matrices with random point streams
  task automatic test_random(int unsigned phases, int unsigned per_phase);
    for (int p = 0; p < phases; p++) begin
      idle_en = (p % 4) != 3;
      for (int i = 0; i < hpt_pkg::NumCfg; i++) write_reg(i, {rand_entry(), rand_entry()});
      if ($urandom_range(0, 3) == 0) write_reg(7, {32'h0, 32'h0001_0000});
      for (int n = 0; n < per_phase; n++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
    idle_en = 1'b1;
  endtask

  // Long output hold while points keep coming, so the core stalls its input
  task automatic test_backpressure();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < 120; n++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
    idle_en = 1'b1;
  endtask

  // Sequence
  initial begin
    foreach (mtx[r, c]) mtx[r][c] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_matrix();
    test_directed();
    test_reg_extremes();
    test_backpressure();
    test_random(28, 50);
    $display("Sent %0d points over directed, extreme and random matrices", pts_sent);
    $display("Checked %0d results (%0d zero-w, %0d clamped), %0d errors",
             res_seen, wz_seen, sat_seen, err_count);
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hpt_pkg.sv
rtl/hpt_matmul.sv
rtl/hpt_div_step.sv
rtl/homogeneous_point_transform_core.sv
dv/tb_homogeneous_point_transform_core.sv
